/* sv/fph_pkg.sv */
// ----------------------------------------------------------------------------
// fph_pkg
// Shared types and constants for the fit-policy hole allocator.
// ----------------------------------------------------------------------------
package fph_pkg;

    localparam int HOLES     = 16;
    localparam int SIZE_BITS = 16;
    localparam int IDX_BITS  = $clog2(HOLES);
    localparam int CNT_BITS  = $clog2(HOLES + 1);

    localparam int CMD_BITS   = 2;
    localparam int MODE_BITS  = 2;
    localparam int CFG_BITS   = 1;
    localparam int CFG_DATA_W = 5;
    localparam int TDATA_W    = 24;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_FIRST  = 2'd0,
        MODE_BEST   = 2'd1,
        MODE_WORST  = 2'd2,
        MODE_SPARE  = 2'd3
    } fit_mode_t;

    localparam logic [CFG_BITS-1:0] CFG_FIT_MODE   = 1'b0;
    localparam logic [CFG_BITS-1:0] CFG_HOLE_COUNT = 1'b1;

    typedef struct packed {
        logic                 rd_en;
        logic [IDX_BITS-1:0]  rd_addr;
        logic                 sz_we;
        logic                 rm_we;
        logic [IDX_BITS-1:0]  wr_addr;
        logic [SIZE_BITS-1:0] sz_wdata;
        logic [SIZE_BITS-1:0] rm_wdata;
    } mem_ctrl_t;

    typedef struct packed {
        logic clear;
        logic step;
    } fit_ctrl_t;

    typedef struct packed {
        logic                 found;
        logic [IDX_BITS-1:0]  pick;
        logic [SIZE_BITS-1:0] best;
    } fit_res_t;

endpackage

/* sv/fph_hole_store.sv */
// ----------------------------------------------------------------------------
// fph_hole_store
// Original and remaining hole sizes, one write and one registered read each.
// ----------------------------------------------------------------------------
module fph_hole_store (
    input  logic                          clk,
    input  fph_pkg::mem_ctrl_t            ctrl,
    output logic [fph_pkg::SIZE_BITS-1:0] sz_rdata,
    output logic [fph_pkg::SIZE_BITS-1:0] rm_rdata
);
    import fph_pkg::*;

    logic [SIZE_BITS-1:0] size_mem [HOLES];
    logic [SIZE_BITS-1:0] rem_mem  [HOLES];

    always_ff @(posedge clk)
    begin
        if (ctrl.sz_we)
        begin
            size_mem[ctrl.wr_addr] <= ctrl.sz_wdata;
        end
        if (ctrl.rd_en)
        begin
            sz_rdata <= size_mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rm_we)
        begin
            rem_mem[ctrl.wr_addr] <= ctrl.rm_wdata;
        end
        if (ctrl.rd_en)
        begin
            rm_rdata <= rem_mem[ctrl.rd_addr];
        end
    end

endmodule

/* sv/fph_fit_unit.sv */
// ----------------------------------------------------------------------------
// fph_fit_unit
// Shared compare unit: takes one candidate hole per step, keeps the pick.
// ----------------------------------------------------------------------------
module fph_fit_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fph_pkg::fit_ctrl_t            ctrl,
    input  fph_pkg::fit_mode_t            mode,
    input  logic [fph_pkg::SIZE_BITS-1:0] need,
    input  logic [fph_pkg::IDX_BITS-1:0]  cand_idx,
    input  logic [fph_pkg::SIZE_BITS-1:0] cand_val,
    output fph_pkg::fit_res_t             res
);
    import fph_pkg::*;

    logic                 found_reg, found_next;
    logic [IDX_BITS-1:0]  pick_reg,  pick_next;
    logic [SIZE_BITS-1:0] best_reg,  best_next;
    logic                 fits;
    logic                 better;
    logic                 take;

    always_comb
    begin
        fits = (cand_val >= need);
        case (mode)
            MODE_BEST:  better = (cand_val < best_reg);
            MODE_WORST: better = (cand_val > best_reg);
            default:    better = 1'b0;
        endcase
        take = ctrl.step && fits && (!found_reg || better);

        found_next = found_reg;
        pick_next  = pick_reg;
        best_next  = best_reg;
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next = 1'b1;
            pick_next  = cand_idx;
            best_next  = cand_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg <= pick_next;
        best_reg <= best_next;
    end

    assign res.found = found_reg;
    assign res.pick  = pick_reg;
    assign res.best  = best_reg;

endmodule

/* sv/fit_policy_hole_allocator.sv */
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator
// Hole table with first, best or worst fit placement of allocate requests.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command request: tuser is the command, tdata the
//   hole index and amount. m_axis returns one result per request: tuser is
//   the grant flag, tdata the placed hole and the size left in it.
//   cfg writes fit_mode (index 0) or hole_count (index 1); write only while
//   the block is idle. cfg_ready is always high.
// Timing:
//   Allocate reads min(hole_count,16) entries of the hole table one entry a
//   cycle through a single registered read port into one shared compare
//   unit. Restart copies the 16 original sizes one per cycle.
//   One request is in progress at a time; s_axis_tready is low meanwhile.
// Reset and stall:
//   Reset clears the sequencer and control registers; the hole table is undefined
//   until loaded. A result waits in the output register while m_axis_tready
//   is low; the next request may be accepted but finishes only once it drains.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fph_pkg::TDATA_W-1:0]     s_axis_tdata,  // hole_index, amount
    input  logic [fph_pkg::CMD_BITS-1:0]    s_axis_tuser,  // command
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fph_pkg::TDATA_W-1:0]     m_axis_tdata,  // placed_hole, left_in_hole
    output logic                            m_axis_tuser,  // granted
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fph_pkg::CFG_BITS-1:0]    cfg_index,
    input  logic [fph_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fph_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COPY   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                 pipe_valid_reg;
    logic [IDX_BITS-1:0]  pipe_idx_reg;
    cmd_t                 cmd_reg;
    logic [IDX_BITS-1:0]  idx_reg;
    logic [SIZE_BITS-1:0] amount_reg;
    fit_mode_t            mode_reg;
    logic [CNT_BITS-1:0]  count_reg;

    logic                 out_valid_reg;
    logic                 out_granted_reg;
    logic [IDX_BITS-1:0]  out_hole_reg;
    logic [SIZE_BITS-1:0] out_left_reg;

    logic [CNT_BITS-1:0]  used;
    logic [CNT_BITS-1:0]  limit;
    logic                 in_acc;
    logic                 out_free;
    logic                 finish_go;
    logic [SIZE_BITS-1:0] left;

    mem_ctrl_t            mem_ctrl;
    fit_ctrl_t            fit_ctrl;
    fit_res_t             fit_res;
    logic [SIZE_BITS-1:0] sz_rdata;
    logic [SIZE_BITS-1:0] rm_rdata;

    fph_hole_store u_store (
        .clk      (clk),
        .ctrl     (mem_ctrl),
        .sz_rdata (sz_rdata),
        .rm_rdata (rm_rdata)
    );

    fph_fit_unit u_fit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (fit_ctrl),
        .mode     (mode_reg),
        .need     (amount_reg),
        .cand_idx (pipe_idx_reg),
        .cand_val (rm_rdata),
        .res      (fit_res)
    );

    assign used      = (count_reg > CNT_BITS'(HOLES)) ? CNT_BITS'(HOLES) : count_reg;
    assign limit     = (state_reg == ST_COPY) ? CNT_BITS'(HOLES) : used;
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign finish_go = (state_reg == ST_FINISH) && out_free;
    assign left      = fit_res.best - amount_reg;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg) inside
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_acc)
                begin
                    case (cmd_t'(s_axis_tuser))
                        CMD_ALLOC:   state_next = ST_SCAN;
                        CMD_RESTART: state_next = ST_COPY;
                        default:     state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN, ST_COPY:
            begin
                if (cnt_reg < limit)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (!pipe_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_ctrl          = '0;
        mem_ctrl.rd_en    = ((state_reg == ST_SCAN) || (state_reg == ST_COPY))
                            && (cnt_reg < limit);
        mem_ctrl.rd_addr  = cnt_reg[IDX_BITS-1:0];
        mem_ctrl.wr_addr  = pipe_idx_reg;
        mem_ctrl.sz_wdata = amount_reg;
        mem_ctrl.rm_wdata = sz_rdata;
        if ((state_reg == ST_COPY) && pipe_valid_reg)
        begin
            mem_ctrl.rm_we = 1'b1;
        end
        else if (finish_go && (cmd_reg == CMD_LOAD))
        begin
            mem_ctrl.sz_we    = 1'b1;
            mem_ctrl.rm_we    = 1'b1;
            mem_ctrl.wr_addr  = idx_reg;
            mem_ctrl.rm_wdata = amount_reg;
        end
        else if (finish_go && (cmd_reg == CMD_ALLOC) && fit_res.found)
        begin
            mem_ctrl.rm_we    = 1'b1;
            mem_ctrl.wr_addr  = fit_res.pick;
            mem_ctrl.rm_wdata = left;
        end
    end

    assign fit_ctrl.clear = in_acc;
    assign fit_ctrl.step  = (state_reg == ST_SCAN) && pipe_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pipe_valid_reg <= 1'b0;
            mode_reg       <= MODE_FIRST;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pipe_valid_reg <= mem_ctrl.rd_en;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FIT_MODE:   mode_reg  <= fit_mode_t'(cfg_data[MODE_BITS-1:0]);
                    CFG_HOLE_COUNT: count_reg <= cfg_data[CNT_BITS-1:0];
                    default:        ;
                endcase
            end
            if (finish_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_idx_reg <= cnt_reg[IDX_BITS-1:0];
        if (in_acc)
        begin
            cmd_reg    <= cmd_t'(s_axis_tuser);
            idx_reg    <= s_axis_tdata[IDX_BITS-1:0];
            amount_reg <= s_axis_tdata[IDX_BITS +: SIZE_BITS];
        end
        if (finish_go)
        begin
            if ((cmd_reg == CMD_ALLOC) && fit_res.found)
            begin
                out_granted_reg <= 1'b1;
                out_hole_reg    <= fit_res.pick;
                out_left_reg    <= left;
            end
            else
            begin
                out_granted_reg <= 1'b0;
                out_hole_reg    <= '0;
                out_left_reg    <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_granted_reg;
    assign m_axis_tdata  = {{(TDATA_W - IDX_BITS - SIZE_BITS){1'b0}}, out_left_reg, out_hole_reg};

`ifndef ASSERT_OFF
    a_pipe_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_valid_reg |-> (state_reg == ST_SCAN) || (state_reg == ST_COPY))
        else $error("read pipeline busy outside a sweep");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> ({1'b0, out_hole_reg} < used))
        else $error("granted hole beyond holes in use");

    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("refused result carries a non-zero payload");

    a_finish_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> !pipe_valid_reg && !mem_ctrl.rd_en)
        else $error("result formed while table reads are still in flight");
`endif

endmodule

/* test/tb_fit_policy_hole_allocator.sv */
// ----------------------------------------------------------------------------
// tb_fit_policy_hole_allocator
// Self-checking bench for the fit-policy hole allocator.
// A directed run loads every hole and covers each command and the corner
// sizes. Random phases then follow under first, best, worst and spare fit
// modes and several hole counts, including counts past the table size.
// A local predictor tracks the hole table and checks each result, field by
// field, in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_fit_policy_hole_allocator;

    import fph_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int CYCLE_CAP  = 600000;
    localparam int PHASES     = 12;
    localparam int PHASE_REQS = 145;

    typedef struct {
        cmd_t                 cmd;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] amt;
    } request_t;

    typedef struct packed {
        logic                 granted;
        logic [IDX_BITS-1:0]  hole;
        logic [SIZE_BITS-1:0] remain;
    } placement_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_W-1:0]     s_axis_tdata = '0;
    logic [CMD_BITS-1:0]    s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    request_t   request_q[$];
    placement_t placement_q[$];

    logic [SIZE_BITS-1:0] size_tab [HOLES];
    logic [SIZE_BITS-1:0] left_tab [HOLES];
    fit_mode_t            mode_r = MODE_FIRST;
    logic [4:0]           count_r = '0;

    logic        req_taken = 1'b0;
    logic        res_taken = 1'b0;
    logic        idle_on = 1'b1;
    int          send_gap = 0;
    int          sink_gap = 0;
    int unsigned pushed_total = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    request_t    nxt;

    fit_policy_hole_allocator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    task automatic place_request(input cmd_t cmd, input logic [IDX_BITS-1:0] idx,
                                 input logic [SIZE_BITS-1:0] amt,
                                 output placement_t res);
        int   used;
        int   pick;
        logic found;
        logic stop;
        res   = '0;
        found = 1'b0;
        stop  = 1'b0;
        pick  = 0;
        case (cmd)
            CMD_LOAD:
            begin
                size_tab[idx] = amt;
                left_tab[idx] = amt;
            end
            CMD_ALLOC:
            begin
                used = (count_r > HOLES) ? HOLES : int'(count_r);
                for (int j = 0; j < HOLES; j++)
                begin
                    if (j < used && !stop && left_tab[j] >= amt)
                    begin
                        if (!found)
                        begin
                            found = 1'b1;
                            pick  = j;
                            stop  = (mode_r != MODE_BEST && mode_r != MODE_WORST);
                        end
                        else if (mode_r == MODE_BEST && left_tab[j] < left_tab[pick])
                            pick = j;
                        else if (mode_r == MODE_WORST && left_tab[j] > left_tab[pick])
                            pick = j;
                    end
                end
                if (found)
                begin
                    left_tab[pick] = left_tab[pick] - amt;
                    res.granted    = 1'b1;
                    res.hole       = pick[IDX_BITS-1:0];
                    res.remain     = left_tab[pick];
                end
            end
            CMD_RESTART:
            begin
                for (int i = 0; i < HOLES; i++)
                    left_tab[i] = size_tab[i];
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want,
                 cycle_count);
    endtask

    // driver: one request per handshake, random gap before the next
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            if (send_gap > 0 || request_q.size() == 0)
            begin
                s_axis_tvalid <= 1'b0;
                if (send_gap > 0)
                    send_gap = send_gap - 1;
            end
            else
            begin
                nxt = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.cmd;
                s_axis_tdata  <= {{(TDATA_W - SIZE_BITS - IDX_BITS){1'b0}}, nxt.amt, nxt.idx};
                send_gap = idle_on ? int'($urandom_range(0, 4)) : 0;
            end
        end
    end

    // result sink: random stall after each result
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
                sink_gap = idle_on ? int'($urandom_range(0, 4)) : 0;
            if (sink_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_gap = sink_gap - 1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        placement_t res;
        placement_t want;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count > CYCLE_CAP)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("*** FAILED ***");
                $finish;
            end
            else
            begin
                req_taken <= s_axis_tvalid && s_axis_tready;
                res_taken <= m_axis_tvalid && m_axis_tready;
                if (cfg_valid && cfg_ready)
                begin
                    case (cfg_index)
                        CFG_FIT_MODE:   mode_r  = fit_mode_t'(cfg_data[MODE_BITS-1:0]);
                        CFG_HOLE_COUNT: count_r = cfg_data;
                        default:        ;
                    endcase
                end
                if (s_axis_tvalid && s_axis_tready)
                begin
                    place_request(cmd_t'(s_axis_tuser), s_axis_tdata[IDX_BITS-1:0],
                                  s_axis_tdata[IDX_BITS +: SIZE_BITS], res);
                    placement_q.push_back(res);
                end
                if (m_axis_tvalid && m_axis_tready)
                begin
                    results_seen++;
                    if (placement_q.size() == 0)
                        report_mismatch("unexpected result",
                                        32'({m_axis_tuser, m_axis_tdata}), 0);
                    else
                    begin
                        want = placement_q.pop_front();
                        if (m_axis_tuser !== want.granted)
                            report_mismatch("granted", 32'(m_axis_tuser),
                                            32'(want.granted));
                        if (m_axis_tdata[IDX_BITS-1:0] !== want.hole)
                            report_mismatch("placed_hole", 32'(m_axis_tdata[IDX_BITS-1:0]),
                                            32'(want.hole));
                        if (m_axis_tdata[IDX_BITS +: SIZE_BITS] !== want.remain)
                            report_mismatch("left_in_hole",
                                            32'(m_axis_tdata[IDX_BITS +: SIZE_BITS]),
                                            32'(want.remain));
                    end
                end
            end
        end
    end

    task automatic push_request(input cmd_t cmd, input logic [IDX_BITS-1:0] idx,
                                input logic [SIZE_BITS-1:0] amt);
        request_t r;
        r.cmd = cmd;
        r.idx = idx;
        r.amt = amt;
        request_q.push_back(r);
        pushed_total++;
    endtask

    // every request returns exactly one result, so idle means all came back
    task automatic wait_idle();
        while (results_seen < pushed_total)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_BITS-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [SIZE_BITS-1:0] hole_size_draw();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r) inside
            0:       return '0;
            1:       return '1;
            2, 3:    return SIZE_BITS'($urandom);
            default: return SIZE_BITS'($urandom_range(1, 3000));
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] alloc_size_draw();
        int unsigned r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return '0;
            1:       return SIZE_BITS'($urandom);
            2:       return '1;
            default: return SIZE_BITS'($urandom_range(1, 600));
        endcase
    endfunction

    task automatic random_phase(input int n);
        int unsigned r;
        for (int i = 0; i < HOLES; i++)
            push_request(CMD_LOAD, i[IDX_BITS-1:0], hole_size_draw());
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                push_request(CMD_LOAD, IDX_BITS'($urandom), hole_size_draw());
            else if (r < 16)
                push_request(CMD_RESTART, IDX_BITS'($urandom), SIZE_BITS'($urandom));
            else if (r < 18)
                push_request(CMD_NOP, IDX_BITS'($urandom), SIZE_BITS'($urandom));
            else
                push_request(CMD_ALLOC, IDX_BITS'($urandom), alloc_size_draw());
            if (k == n / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    initial
    begin
        fit_mode_t  modes  [PHASES];
        logic [4:0] counts [PHASES];
        modes  = '{MODE_FIRST, MODE_BEST, MODE_WORST, MODE_SPARE, MODE_BEST, MODE_WORST,
                   MODE_FIRST, MODE_BEST, MODE_WORST, MODE_BEST, MODE_WORST, MODE_FIRST};
        counts = '{5'd16, 5'd16, 5'd16, 5'd9, 5'd1, 5'd0,
                   5'd31, 5'd17, 5'd3, 5'd16, 5'd12, 5'd16};
        for (int i = 0; i < HOLES; i++)
        begin
            size_tab[i] = '0;
            left_tab[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_reg(CFG_FIT_MODE, CFG_DATA_W'(MODE_FIRST));
        write_reg(CFG_HOLE_COUNT, CFG_DATA_W'(HOLES));

        // directed: fill the table, then corner sizes and every command
        push_request(CMD_LOAD, 4'd0, 16'h0000);
        push_request(CMD_LOAD, 4'd15, 16'hFFFF);
        push_request(CMD_LOAD, 4'd1, 16'h0001);
        push_request(CMD_LOAD, 4'd2, 16'h5555);
        push_request(CMD_LOAD, 4'd3, 16'hAAAA);
        push_request(CMD_LOAD, 4'd4, 16'h8000);
        push_request(CMD_LOAD, 4'd5, 16'h00FF);
        push_request(CMD_LOAD, 4'd6, 16'h0FF0);
        push_request(CMD_LOAD, 4'd7, 16'd300);
        push_request(CMD_LOAD, 4'd8, 16'd300);
        push_request(CMD_LOAD, 4'd9, 16'd50);
        push_request(CMD_LOAD, 4'd10, 16'd1000);
        push_request(CMD_LOAD, 4'd11, 16'd7);
        push_request(CMD_LOAD, 4'd12, 16'h7FFF);
        push_request(CMD_LOAD, 4'd13, 16'd200);
        push_request(CMD_LOAD, 4'd14, 16'd12);
        push_request(CMD_ALLOC, 4'd0, 16'h0000);    // zero request fits an empty hole
        push_request(CMD_ALLOC, 4'd0, 16'hFFFF);
        push_request(CMD_ALLOC, 4'hF, 16'hFFFF);    // nothing left that big
        push_request(CMD_ALLOC, 4'd0, 16'd300);
        push_request(CMD_NOP, 4'hF, 16'hFFFF);
        push_request(CMD_RESTART, 4'd0, 16'h0000);
        push_request(CMD_ALLOC, 4'd5, 16'hFFFF);
        push_request(CMD_NOP, 4'd0, 16'h0000);
        wait_idle();

        for (int p = 0; p < PHASES; p++)
        begin
            idle_on = (p % 4) != 3;
            write_reg(CFG_FIT_MODE, CFG_DATA_W'(modes[p]));
            write_reg(CFG_HOLE_COUNT, counts[p]);
            random_phase(PHASE_REQS);
        end

        idle_on = 1'b1;
        wait_idle();
        repeat (20) @(negedge clk);
        if (mismatches == 0 && placement_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
